FILE: rtl/core/pfc_pkg.sv
// Shared types, register indexes and helper functions for the pixel format converter.
`default_nettype none

package pfc_pkg;

    // Pixel format codes, shared by the source and target registers
    typedef enum logic [1:0] {
        FMT_ARGB8888 = 2'd0,
        FMT_RGB565   = 2'd1,
        FMT_ARGB1555 = 2'd2,
        FMT_ARGB4444 = 2'd3
    } fmt_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_SOURCE_FORMAT      = 3'd0,
        REG_TARGET_FORMAT      = 3'd1,
        REG_SWAP_RED_BLUE      = 3'd2,
        REG_KEEP_ALPHA         = 3'd3,
        REG_KEY_COLOR          = 3'd4,
        REG_NEAR_ZERO_ALPHA    = 3'd5,
        REG_REPLACE_ENABLE_MIN = 3'd6,
        REG_UNUSED             = 3'd7
    } cfg_reg_t;

    localparam logic [7:0]  ALPHA_OPAQUE    = 8'hFF;
    localparam logic [7:0]  ALPHA_1555_MIN  = 8'h40;

    // Configuration state as seen by the datapath
    typedef struct packed {
        fmt_t        source_format;
        fmt_t        target_format;
        logic        swap_red_blue;
        logic        keep_alpha;
        logic [31:0] key_color;
        logic [7:0]  near_zero_alpha;
        logic [31:0] replace_enable_min;
    } cfg_t;

    // One pixel widened to 8-bit channels
    typedef struct packed {
        logic [7:0] a;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } pix_t;

    function automatic logic [7:0] widen5(input logic [4:0] v);
        return {v, v[4:2]};
    endfunction

    function automatic logic [7:0] widen6(input logic [5:0] v);
        return {v, v[5:4]};
    endfunction

    function automatic logic [7:0] widen4(input logic [3:0] v);
        return {v, v};
    endfunction

    // floor(x / 255), exact for x below 65280
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
        return t[15:8];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/pixel_format_converter.sv
// Top level: config registers and the four-register pixel conversion pipeline.
// Words pass through the input, decode, product and output registers (four register stages).
// Throughput: one word per cycle while m_ready holds; the 565 blend multipliers sit in their own stage.
// Each stage advances when the stage after it is empty or moving, so a stalled
// result does not stop the input until all four registers are full.
// Reset (aresetn low, synchronous) empties the pipeline and loads register defaults.
`default_nettype none

module pixel_format_converter
    import pfc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    // input pixel channel
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_pixel_in,
    // result pixel channel
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_pixel_out
);

    cfg_t        cfg_reg;
    logic        in_valid_reg;
    logic [31:0] in_pixel_reg;
    logic        chan_valid_reg;
    pix_t        chan_reg;
    pix_t        chan_next;
    logic        prod_valid_reg;
    logic [15:0] prod_c_reg [3];
    logic [15:0] prod_k_reg [3];
    logic [31:0] packed_reg;
    logic [31:0] packed_next;
    logic        out_valid_reg;
    logic [31:0] out_pixel_reg;
    logic [31:0] out_pixel_next;
    logic [7:0]  inv_alpha;
    logic [7:0]  blend_ch [3];
    logic        adv_out;
    logic        adv_prod;
    logic        adv_chan;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.source_format      <= FMT_ARGB8888;
            cfg_reg.target_format      <= FMT_RGB565;
            cfg_reg.swap_red_blue      <= 1'b0;
            cfg_reg.keep_alpha         <= 1'b1;
            cfg_reg.key_color          <= 32'h0000_0000;
            cfg_reg.near_zero_alpha    <= 8'h00;
            cfg_reg.replace_enable_min <= 32'h0100_0000;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_SOURCE_FORMAT:      cfg_reg.source_format      <= fmt_t'(cfg_data[1:0]);
                REG_TARGET_FORMAT:      cfg_reg.target_format      <= fmt_t'(cfg_data[1:0]);
                REG_SWAP_RED_BLUE:      cfg_reg.swap_red_blue      <= cfg_data[0];
                REG_KEEP_ALPHA:         cfg_reg.keep_alpha         <= cfg_data[0];
                REG_KEY_COLOR:          cfg_reg.key_color          <= cfg_data;
                REG_NEAR_ZERO_ALPHA:    cfg_reg.near_zero_alpha    <= cfg_data[7:0];
                REG_REPLACE_ENABLE_MIN: cfg_reg.replace_enable_min <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Pipeline flow control
    assign adv_out  = !out_valid_reg || m_ready;
    assign adv_prod = !prod_valid_reg || adv_out;
    assign adv_chan = !chan_valid_reg || adv_prod;
    assign s_ready  = !in_valid_reg || adv_chan;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            chan_valid_reg <= 1'b0;
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (adv_chan) begin
                chan_valid_reg <= in_valid_reg;
            end
            if (adv_prod) begin
                prod_valid_reg <= chan_valid_reg;
            end
            if (adv_out) begin
                out_valid_reg <= prod_valid_reg;
            end
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_pixel_reg <= s_pixel_in;
        end
    end

    // Decode stage
    pfc_unpack u_unpack (
        .pixel (in_pixel_reg),
        .cfg   (cfg_reg),
        .pix   (chan_next)
    );

    always_ff @(posedge aclk) begin
        if (adv_chan && in_valid_reg) begin
            chan_reg <= chan_next;
        end
    end

    // Product stage: blend products for 565, direct packing for the others
    assign inv_alpha = ALPHA_OPAQUE - chan_reg.a;

    always_comb begin
        unique case (cfg_reg.target_format)
            FMT_ARGB8888: packed_next = chan_reg;
            FMT_ARGB1555: packed_next = {16'h0000, (chan_reg.a >= ALPHA_1555_MIN),
                                         chan_reg.r[7:3], chan_reg.g[7:3], chan_reg.b[7:3]};
            FMT_ARGB4444: packed_next = {16'h0000, chan_reg.a[7:4], chan_reg.r[7:4],
                                         chan_reg.g[7:4], chan_reg.b[7:4]};
            default:      packed_next = 32'h0000_0000;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (adv_prod && chan_valid_reg) begin
            prod_c_reg[2] <= {8'h00, chan_reg.r} * {8'h00, chan_reg.a};
            prod_c_reg[1] <= {8'h00, chan_reg.g} * {8'h00, chan_reg.a};
            prod_c_reg[0] <= {8'h00, chan_reg.b} * {8'h00, chan_reg.a};
            prod_k_reg[2] <= {8'h00, cfg_reg.key_color[23:16]} * {8'h00, inv_alpha};
            prod_k_reg[1] <= {8'h00, cfg_reg.key_color[15:8]} * {8'h00, inv_alpha};
            prod_k_reg[0] <= {8'h00, cfg_reg.key_color[7:0]} * {8'h00, inv_alpha};
            packed_reg    <= packed_next;
        end
    end

    // Output stage: divide by 255, sum and pack 565
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            blend_ch[i] = div255(prod_c_reg[i]) + div255(prod_k_reg[i]);
        end
        if (cfg_reg.target_format == FMT_RGB565) begin
            out_pixel_next = {16'h0000, blend_ch[2][7:3], blend_ch[1][7:2], blend_ch[0][7:3]};
        end else begin
            out_pixel_next = packed_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_out && prod_valid_reg) begin
            out_pixel_reg <= out_pixel_next;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_pixel_out = out_pixel_reg;

    // Narrow targets never drive the upper half
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && cfg_reg.target_format != FMT_ARGB8888) |-> (m_pixel_out[31:16] == 16'h0000))
        else $error("upper half set for a 16-bit target");

    // An empty pipeline always takes a new word
    assert property (@(posedge aclk) disable iff (!aresetn)
        (!in_valid_reg && !chan_valid_reg && !prod_valid_reg && !out_valid_reg) |-> s_ready)
        else $error("empty pipeline refuses input");

    // A full, stalled pipeline refuses new input
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && chan_valid_reg && prod_valid_reg && out_valid_reg && !m_ready)
        |-> !s_ready)
        else $error("full pipeline accepted input while stalled");

    // Green blend result never overflows its channel
    assert property (@(posedge aclk) disable iff (!aresetn)
        prod_valid_reg |-> ({1'b0, div255(prod_c_reg[1])} + {1'b0, div255(prod_k_reg[1])}
                            <= 9'd255))
        else $error("blend sum above full scale");

endmodule

`default_nettype wire

FILE: rtl/core/pfc_unpack.sv
// Source decode, channel widening, red/blue swap, key replacement and alpha forcing.
`default_nettype none

module pfc_unpack
    import pfc_pkg::*;
(
    input  wire logic [31:0] pixel,
    input  wire cfg_t        cfg,
    output pix_t             pix
);

    pix_t wide;
    pix_t swapped;
    logic has_alpha;
    logic replace;

    // Widen source channels to 8 bits
    always_comb begin
        has_alpha = 1'b1;
        unique case (cfg.source_format)
            FMT_ARGB8888: begin
                wide = pixel;
            end
            FMT_RGB565: begin
                wide.b    = widen5(pixel[4:0]);
                wide.g    = widen6(pixel[10:5]);
                wide.r    = widen5(pixel[15:11]);
                wide.a    = ALPHA_OPAQUE;
                has_alpha = 1'b0;
            end
            FMT_ARGB1555: begin
                wide.b = widen5(pixel[4:0]);
                wide.g = widen5(pixel[9:5]);
                wide.r = widen5(pixel[14:10]);
                wide.a = pixel[15] ? ALPHA_OPAQUE : 8'h00;
            end
            FMT_ARGB4444: begin
                wide.b = widen4(pixel[3:0]);
                wide.g = widen4(pixel[7:4]);
                wide.r = widen4(pixel[11:8]);
                wide.a = widen4(pixel[15:12]);
            end
            default: begin
                wide = pixel;
            end
        endcase
    end

    // Swap, then key replacement for near-transparent pixels (not toward 565)
    always_comb begin
        swapped   = wide;
        if (cfg.swap_red_blue) begin
            swapped.r = wide.b;
            swapped.b = wide.r;
        end
        replace = has_alpha && (cfg.target_format != FMT_RGB565)
                  && (wide.a <= cfg.near_zero_alpha)
                  && (cfg.key_color >= cfg.replace_enable_min);
        pix = swapped;
        if (replace) begin
            pix.r = cfg.key_color[23:16];
            pix.g = cfg.key_color[15:8];
            pix.b = cfg.key_color[7:0];
        end
        // alpha of a 565 source is already opaque
        if (!cfg.keep_alpha) begin
            pix.a = ALPHA_OPAQUE;
        end
    end

endmodule

`default_nettype wire
